@@ rtl/snm_pkg.sv @@
`timescale 1ns / 1ps

package snm_pkg;

	// Sizes of the neuron datapath.
	localparam int MAX_INPUTS = 64;
	localparam int DATA_WIDTH = 16;
	localparam int INDEX_WIDTH = 6;
	localparam int ACC_BITS = 40;
	localparam int FRAC_BITS = 12;
	localparam int ADDR_WIDTH = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;

	// Activation values lie in 0..Q_ONE, which needs this many bits.
	localparam int ACT_WIDTH = FRAC_BITS + 1;
	localparam logic [ACT_WIDTH-1:0] Q_ONE = ACT_WIDTH'(1 << FRAC_BITS);

	// Command codes.
	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_ACCUM = 2'd1;
	localparam logic [1:0] CMD_DELTA = 2'd2;

	// Result kinds.
	localparam logic KIND_ACT = 1'b0;
	localparam logic KIND_DELTA = 1'b1;

	typedef struct packed {
		logic [1:0] cmd;
		logic [INDEX_WIDTH-1:0] index;
		logic signed [DATA_WIDTH-1:0] data;
		logic last;
	} item_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] result_value;
		logic result_kind;
	} result_t;

endpackage

@@ rtl/snm_plan.sv @@
`timescale 1ns / 1ps

module snm_plan (
	input logic signed [snm_pkg::DATA_WIDTH-1:0] x,
	output logic [snm_pkg::ACT_WIDTH-1:0] y
);
	import snm_pkg::*;

	// Segment boundaries of the piecewise-linear curve in Q4.12, and segment offsets in Q1.12.
	localparam logic [DATA_WIDTH-1:0] A_SAT = DATA_WIDTH'(20480);
	localparam logic [DATA_WIDTH-1:0] A_MID = DATA_WIDTH'(9728);
	localparam logic [DATA_WIDTH-1:0] A_ONE = DATA_WIDTH'(4096);
	localparam logic [ACT_WIDTH-1:0] B_HIGH = ACT_WIDTH'(3456);
	localparam logic [ACT_WIDTH-1:0] B_MID = ACT_WIDTH'(2560);
	localparam logic [ACT_WIDTH-1:0] B_LOW = ACT_WIDTH'(2048);

	logic [DATA_WIDTH-1:0] mag;
	logic [ACT_WIDTH-1:0] pos_y;

	// Magnitude of the input; the most negative value fits as unsigned.
	assign mag = x[DATA_WIDTH-1] ? DATA_WIDTH'(-x) : DATA_WIDTH'(x);

	// Curve for the positive half.
	always_comb begin
		priority if (mag >= A_SAT) begin
			pos_y = Q_ONE;
		end else if (mag >= A_MID) begin
			pos_y = ACT_WIDTH'(mag >> 5) + B_HIGH;
		end else if (mag >= A_ONE) begin
			pos_y = ACT_WIDTH'(mag >> 3) + B_MID;
		end else begin
			pos_y = ACT_WIDTH'(mag >> 2) + B_LOW;
		end
	end

	// The negative half mirrors the curve around one half.
	assign y = x[DATA_WIDTH-1] ? (Q_ONE - pos_y) : pos_y;

endmodule

@@ rtl/sigmoid_neuron_mac.sv @@
`timescale 1ns / 1ps
// Steps: a weight write leaves the input free; an accumulate runs the weight memory read,
// multiply and add, and with last also saturate and sigmoid; a delta runs derivative,
// product and output. One transaction at a time; sigmoid and output wait on a stalled result.
// The result sits in an output register, so the next item is taken while it waits.
// Reset clears the accumulator, the neuron value, the state and the result valid flag; weights stay undefined.
module sigmoid_neuron_mac (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_stall,
	input snm_pkg::item_t item,
	output logic result_valid,
	input logic result_stall,
	output snm_pkg::result_t result
);
	import snm_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL = 3'd1;
	localparam logic [2:0] S_ACC = 3'd2;
	localparam logic [2:0] S_SAT = 3'd3;
	localparam logic [2:0] S_SIG = 3'd4;
	localparam logic [2:0] S_DER = 3'd5;
	localparam logic [2:0] S_DPR = 3'd6;
	localparam logic [2:0] S_DOUT = 3'd7;

	localparam int PROD_WIDTH = 2 * DATA_WIDTH;
	localparam int SHIFT_WIDTH = ACC_BITS - FRAC_BITS;
	localparam int DER_WIDTH = 2 * FRAC_BITS - 1;
	localparam int DPROD_WIDTH = DATA_WIDTH + DER_WIDTH + 1;

	logic [2:0] state_q;
	logic [DATA_WIDTH-1:0] weight_mem [MAX_INPUTS];
	logic signed [DATA_WIDTH-1:0] weight_q;
	logic signed [DATA_WIDTH-1:0] data_q;
	logic last_q;
	logic in_range_q;
	logic signed [PROD_WIDTH-1:0] prod_q;
	logic signed [ACC_BITS-1:0] acc_q;
	logic signed [DATA_WIDTH-1:0] x_q;
	logic [ACT_WIDTH-1:0] nv_q;
	logic [DER_WIDTH-1:0] der_q;
	logic signed [DPROD_WIDTH-1:0] dprod_q;
	logic result_valid_q;
	result_t result_q;

	logic accept;
	logic in_range;
	logic [ADDR_WIDTH-1:0] addr;
	logic load_out;
	logic signed [SHIFT_WIDTH-1:0] acc_shift;
	logic signed [DATA_WIDTH-1:0] acc_sat;
	logic [ACT_WIDTH-1:0] act;
	logic [2*ACT_WIDTH-1:0] der_full;
	logic [ACT_WIDTH-1:0] one_minus;

	assign accept = item_valid && !item_stall;
	assign item_stall = (state_q != S_IDLE);
	assign in_range = (32'(item.index) < MAX_INPUTS);
	assign addr = ADDR_WIDTH'(item.index);
	assign load_out = !result_valid_q || !result_stall;

	// Weight memory: a write and a read never share a cycle, so a read
	// always sees every earlier write.
	always_ff @(posedge clk) begin
		if (accept && item.cmd == CMD_WRITE && in_range) begin
			weight_mem[addr] <= item.data;
		end
		if (accept && item.cmd == CMD_ACCUM && in_range) begin
			weight_q <= weight_mem[addr];
		end
	end

	// Floor shift of the sum to Q4.12 with saturation.
	assign acc_shift = acc_q[ACC_BITS-1:FRAC_BITS];
	always_comb begin
		priority if (acc_shift > SHIFT_WIDTH'(signed'(32'(2 ** (DATA_WIDTH - 1) - 1)))) begin
			acc_sat = {1'b0, {(DATA_WIDTH-1){1'b1}}};
		end else if (acc_shift < -SHIFT_WIDTH'(signed'(32'(2 ** (DATA_WIDTH - 1))))) begin
			acc_sat = {1'b1, {(DATA_WIDTH-1){1'b0}}};
		end else begin
			acc_sat = acc_shift[DATA_WIDTH-1:0];
		end
	end

	snm_plan u_plan (
		.x(x_q),
		.y(act)
	);

	// Derivative of the stored activation, v * (1 - v), at most one quarter.
	assign one_minus = Q_ONE - nv_q;
	assign der_full = nv_q * one_minus;

	// Sequencer and datapath registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			acc_q <= '0;
			nv_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						data_q <= item.data;
						last_q <= item.last;
						in_range_q <= in_range;
						if (item.cmd == CMD_ACCUM) begin
							state_q <= S_MUL;
						end else if (item.cmd == CMD_DELTA) begin
							state_q <= S_DER;
						end
					end
				end
				S_MUL: begin
					prod_q <= in_range_q ? PROD_WIDTH'(weight_q * data_q) : '0;
					state_q <= S_ACC;
				end
				S_ACC: begin
					acc_q <= acc_q + ACC_BITS'(prod_q);
					state_q <= last_q ? S_SAT : S_IDLE;
				end
				S_SAT: begin
					x_q <= acc_sat;
					acc_q <= '0;
					state_q <= S_SIG;
				end
				S_SIG: begin
					if (load_out) begin
						nv_q <= act;
						state_q <= S_IDLE;
					end
				end
				S_DER: begin
					der_q <= der_full[DER_WIDTH-1:0];
					state_q <= S_DPR;
				end
				S_DPR: begin
					dprod_q <= DPROD_WIDTH'(data_q * signed'({1'b0, der_q}));
					state_q <= S_DOUT;
				end
				S_DOUT: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output register; the delta stays within about two to the thirteenth,
	// so its top bits after the floor shift need no saturation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			if (state_q == S_SIG && load_out) begin
				result_valid_q <= 1'b1;
				result_q.result_value <= DATA_WIDTH'(act);
				result_q.result_kind <= KIND_ACT;
			end else if (state_q == S_DOUT && load_out) begin
				result_valid_q <= 1'b1;
				result_q.result_value <= dprod_q[2*FRAC_BITS +: DATA_WIDTH];
				result_q.result_kind <= KIND_DELTA;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

endmodule

@@ rtl/snm_checker.sv @@
`timescale 1ns / 1ps

module snm_checker (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	input logic item_stall,
	input snm_pkg::item_t item,
	input logic result_valid,
	input logic result_stall,
	input snm_pkg::result_t result
);
	import snm_pkg::*;

	// A stalled result stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(result))
		else $error("result changed while stalled");

	// A weight write does not hold the input.
	assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && item.cmd == CMD_WRITE |=> !item_stall)
		else $error("weight write held the input");

	// An accumulate occupies the datapath for the following cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && item.cmd == CMD_ACCUM |=> item_stall)
		else $error("accumulate did not hold the input");

	// An activation lies between zero and one.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.result_kind == KIND_ACT |->
			result.result_value >= 0 && result.result_value <= DATA_WIDTH'(Q_ONE))
		else $error("activation out of range");

endmodule

bind sigmoid_neuron_mac snm_checker u_snm_checker (
	.clk(clk),
	.arst_n(arst_n),
	.item_valid(item_valid),
	.item_stall(item_stall),
	.item(item),
	.result_valid(result_valid),
	.result_stall(result_stall),
	.result(result)
);
